[hw/rtl/physical_page_range_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Physical page range allocator assertion macros
// Clocked property checks, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PHYSICAL_PAGE_RANGE_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_PAGE_RANGE_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("ppra check failed");
`define ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error("ppra never failed");
`else
`define ASSERT_CLK(lbl, ck, rs, prop)
`define ASSERT_NEVER(lbl, ck, rs, cond)
`endif
`endif

[hw/rtl/ppra_pkg.sv]
// ----------------------------------------------------------------------------
// ppra_pkg
// Shared constants, codes and types of the physical page range allocator.
// ----------------------------------------------------------------------------
package ppra_pkg;

  localparam int MAX_RANGES  = 16;
  localparam int IDX_W       = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int USED_W      = $clog2(MAX_RANGES + 1);
  localparam int ADDR_W      = 52;
  localparam int END_W       = ADDR_W + 1;
  localparam int TOTAL_W     = 56;
  localparam int PAGE_W      = 40;
  localparam int PAGE_SHIFT  = 12;
  localparam int RNUM_W      = 4;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_ADD     = 2'd0;
  localparam op_t OP_START   = 2'd1;
  localparam op_t OP_ACQUIRE = 2'd2;
  localparam op_t OP_CONTAIN = 2'd3;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK            = 3'd0;
  localparam status_t ST_TABLE_FULL    = 3'd1;
  localparam status_t ST_NOT_FOUND     = 3'd2;
  localparam status_t ST_OUT_OF_MEMORY = 3'd3;
  localparam status_t ST_NOT_STARTED   = 3'd4;
  localparam status_t ST_MISALIGNED    = 3'd5;

  typedef struct packed {
    op_t              op;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [END_W-1:0]  span_end;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [END_W-1:0]  end_addr;
    logic [PAGE_W-1:0] page_total;
  } tbl_t;

endpackage

[hw/rtl/ppra_front.sv]
// ----------------------------------------------------------------------------
// ppra_front
// Accepts request words, forms the span end and pushes commands to the queue.
// ----------------------------------------------------------------------------
module ppra_front (
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ppra_pkg::op_t                opcode,
  input  logic [ppra_pkg::ADDR_W-1:0]  range_address,
  input  logic [ppra_pkg::ADDR_W-1:0]  span_size,
  input  logic                         q_full,
  output logic                         q_push,
  output ppra_pkg::cmd_t               q_cmd
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.op       = opcode;
    q_cmd.addr     = range_address;
    q_cmd.size     = span_size;
    q_cmd.span_end = {1'b0, range_address} + {1'b0, span_size};
  end

endmodule

[hw/rtl/ppra_queue.sv]
// ----------------------------------------------------------------------------
// ppra_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ppra_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppra_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output ppra_pkg::cmd_t pop_cmd,
  output logic           empty
);

  localparam int PtrW = ppra_pkg::QPTR_W;
  localparam int CntW = ppra_pkg::QCNT_W;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(ppra_pkg::QUEUE_DEPTH - 1);

  ppra_pkg::cmd_t  slots [ppra_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = count == CntW'(ppra_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/ppra_back.sv]
// ----------------------------------------------------------------------------
// ppra_back
// Executes commands against the range table and drives the result register.
// ----------------------------------------------------------------------------
`include "physical_page_range_allocator_assert.svh"

module ppra_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  ppra_pkg::cmd_t                q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppra_pkg::status_t             status,
  output logic [ppra_pkg::ADDR_W-1:0]   granted_page,
  output logic [ppra_pkg::RNUM_W-1:0]   range_number,
  output logic                          contained,
  output logic [ppra_pkg::TOTAL_W-1:0]  total_bytes
);

  localparam int IdxW   = ppra_pkg::IDX_W;
  localparam int UsedW  = ppra_pkg::USED_W;
  localparam int RnumW  = ppra_pkg::RNUM_W;
  localparam int TotalW = ppra_pkg::TOTAL_W;
  localparam int PageW  = ppra_pkg::PAGE_W;
  localparam int AddrW  = ppra_pkg::ADDR_W;
  localparam int Shift  = ppra_pkg::PAGE_SHIFT;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD      = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_ACQ      = 3'd3;
  localparam logic [2:0] S_ACQ_NEXT = 3'd4;

  logic [2:0]        state;
  ppra_pkg::cmd_t    cmd;
  ppra_pkg::tbl_t    tbl [ppra_pkg::MAX_RANGES];
  ppra_pkg::tbl_t    rd_data;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   rd_idx;
  logic              rd_live;
  logic [UsedW-1:0]  range_used;
  logic [UsedW-1:0]  scan_idx;
  logic [IdxW-1:0]   cursor_range;
  logic [PageW-1:0]  cursor_page;
  logic              cursor_valid;
  logic [TotalW-1:0] byte_total;

  logic              table_full;
  logic              tbl_we;
  logic [UsedW-1:0]  next_range;
  logic              next_ok;
  logic              scan_more;
  logic              hit;
  logic              misaligned;
  logic              page_left;
  logic [AddrW-1:0]  start_off;

  logic              res_fire;
  ppra_pkg::status_t res_status;
  logic [AddrW-1:0]  res_page;
  logic [RnumW-1:0]  res_rnum;
  logic              res_cont;
  logic [TotalW-1:0] res_total;

  assign q_pop      = (state == S_IDLE) && !q_empty && !out_valid;
  assign table_full = range_used == UsedW'(ppra_pkg::MAX_RANGES);
  assign tbl_we     = (state == S_ADD) && !table_full;
  assign next_range = UsedW'(cursor_range) + UsedW'(1);
  assign next_ok    = next_range < range_used;
  assign scan_more  = scan_idx < range_used;
  assign page_left  = cursor_page < rd_data.page_total;
  assign misaligned = cmd.addr[Shift-1:0] != rd_data.base[Shift-1:0];
  assign start_off  = cmd.addr - rd_data.base;

  always_comb begin
    hit = 1'b0;
    if (rd_live && (cmd.addr >= rd_data.base)) begin
      if (cmd.op == ppra_pkg::OP_START) begin
        hit = {1'b0, cmd.addr} <= rd_data.end_addr;
      end else begin
        hit = cmd.span_end <= rd_data.end_addr;
      end
    end
  end

  always_comb begin
    unique case (state)
      S_SCAN:  rd_addr = scan_idx[IdxW-1:0];
      S_ACQ:   rd_addr = next_range[IdxW-1:0];
      default: rd_addr = cursor_range;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[range_used[IdxW-1:0]] <= '{base: cmd.addr, end_addr: cmd.span_end,
                                     page_total: cmd.size[AddrW-1:Shift]};
    end
    rd_data <= tbl[rd_addr];
  end

  always_comb begin
    res_fire   = 1'b0;
    res_status = ppra_pkg::ST_OK;
    res_page   = '0;
    res_rnum   = '0;
    res_cont   = 1'b0;
    res_total  = byte_total;
    unique case (state)
      S_ADD: begin
        res_fire = 1'b1;
        if (table_full) begin
          res_status = ppra_pkg::ST_TABLE_FULL;
        end else begin
          res_total = byte_total + TotalW'(cmd.size);
        end
      end
      S_SCAN: begin
        res_fire = hit || !scan_more;
        if (cmd.op == ppra_pkg::OP_START) begin
          if (hit) begin
            res_rnum   = RnumW'(rd_idx);
            res_status = misaligned ? ppra_pkg::ST_MISALIGNED : ppra_pkg::ST_OK;
          end else begin
            res_status = ppra_pkg::ST_NOT_FOUND;
          end
        end else begin
          res_cont = hit;
        end
      end
      S_ACQ: begin
        res_fire = !cursor_valid || page_left || !next_ok;
        if (!cursor_valid) begin
          res_status = ppra_pkg::ST_NOT_STARTED;
        end else if (page_left) begin
          res_page = rd_data.base + {cursor_page, {Shift{1'b0}}};
          res_rnum = RnumW'(cursor_range);
        end else begin
          res_status = ppra_pkg::ST_OUT_OF_MEMORY;
        end
      end
      S_ACQ_NEXT: begin
        res_fire = 1'b1;
        res_page = rd_data.base;
        res_rnum = RnumW'(next_range);
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      range_used   <= '0;
      scan_idx     <= '0;
      rd_live      <= 1'b0;
      cursor_range <= '0;
      cursor_page  <= '0;
      cursor_valid <= 1'b0;
      byte_total   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd      <= q_data;
            scan_idx <= '0;
            rd_live  <= 1'b0;
            unique case (q_data.op) inside
              ppra_pkg::OP_ADD:                      state <= S_ADD;
              ppra_pkg::OP_START, ppra_pkg::OP_CONTAIN: state <= S_SCAN;
              ppra_pkg::OP_ACQUIRE:                  state <= S_ACQ;
            endcase
          end
        end
        S_ADD: begin
          if (!table_full) begin
            range_used <= range_used + UsedW'(1);
            byte_total <= res_total;
          end
        end
        S_SCAN: begin
          rd_live <= scan_more;
          if (scan_more) begin
            scan_idx <= scan_idx + UsedW'(1);
            rd_idx   <= scan_idx[IdxW-1:0];
          end
          if (hit && (cmd.op == ppra_pkg::OP_START) && !misaligned) begin
            cursor_range <= rd_idx;
            cursor_page  <= start_off[AddrW-1:Shift];
            cursor_valid <= 1'b1;
          end
        end
        S_ACQ: begin
          if (cursor_valid) begin
            if (page_left) begin
              cursor_page <= cursor_page + PageW'(1);
            end else if (next_ok) begin
              state <= S_ACQ_NEXT;
            end
          end
        end
        S_ACQ_NEXT: begin
          cursor_range <= next_range[IdxW-1:0];
          cursor_page  <= PageW'(1);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (res_fire) begin
        state        <= S_IDLE;
        out_valid    <= 1'b1;
        status       <= res_status;
        granted_page <= res_page;
        range_number <= res_rnum;
        contained    <= res_cont;
        total_bytes  <= res_total;
      end
    end
  end

  `ASSERT_NEVER(a_used_bound, clk, rst, range_used > UsedW'(ppra_pkg::MAX_RANGES))
  `ASSERT_CLK(a_busy_out_free, clk, rst, (state != S_IDLE) |-> !out_valid)
  `ASSERT_CLK(a_cursor_in_table, clk, rst, cursor_valid |-> (UsedW'(cursor_range) < range_used))
  `ASSERT_CLK(a_pop_leaves_idle, clk, rst, q_pop |=> (state != S_IDLE))

endmodule

[hw/rtl/physical_page_range_allocator.sv]
// ----------------------------------------------------------------------------
// physical_page_range_allocator
// Bump allocator of 4 KB pages over a table of physical memory ranges.
// ----------------------------------------------------------------------------
// Request channel: in_valid/in_stall carry opcode, range_address, span_size.
// Result channel: out_valid/out_stall carry status, granted_page,
// range_number, contained and total_bytes; one result word per request.
// Requests enter a two-entry queue; the back part runs one at a time.
// Add runs in an add state; acquire runs in an acquire state, then in a
// next-range state when it steps to the next range; start and
// containment scan the table one entry per cycle, reading up to the
// ranges in use. Each result is registered into the result word.
// The back part takes no new request while its result word waits.
// Reset clears the table count, the cursor and the byte total; no table
// clearing pass is run. A stalled result holds its word; the queue keeps
// taking requests until it fills, then in_stall rises.
// ----------------------------------------------------------------------------
module physical_page_range_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ppra_pkg::op_t                 opcode,
  input  logic [ppra_pkg::ADDR_W-1:0]   range_address,
  input  logic [ppra_pkg::ADDR_W-1:0]   span_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ppra_pkg::status_t             status,
  output logic [ppra_pkg::ADDR_W-1:0]   granted_page,
  output logic [ppra_pkg::RNUM_W-1:0]   range_number,
  output logic                          contained,
  output logic [ppra_pkg::TOTAL_W-1:0]  total_bytes
);

  logic           q_full;
  logic           q_push;
  ppra_pkg::cmd_t q_cmd;
  logic           q_pop;
  ppra_pkg::cmd_t q_data;
  logic           q_empty;

  ppra_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .range_address (range_address),
    .span_size     (span_size),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  ppra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_data),
    .empty    (q_empty)
  );

  ppra_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_page (granted_page),
    .range_number (range_number),
    .contained    (contained),
    .total_bytes  (total_bytes)
  );

endmodule
